// ----- hdl/midi_acia_cartridge_top_defines.svh -----
// Assertion macros for the MIDI ACIA cartridge checker.
`ifndef MIDI_ACIA_CARTRIDGE_TOP_DEFINES_SVH
`define MIDI_ACIA_CARTRIDGE_TOP_DEFINES_SVH

// Same-cycle implication, switched off while reset is held.
`define MA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off while reset is held.
`define MA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also watches the reset itself.
`define MA_ASSERT_RESET(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/midi_acia_pkg.sv -----
// Package: types, address map and character period table for the MIDI ACIA cartridge.
`timescale 1ns / 1ps

package midi_acia_pkg;

    typedef enum logic [1:0] {
        FUNC_READ  = 2'd0,
        FUNC_WRITE = 2'd1,
        FUNC_TICK  = 2'd2,
        FUNC_NOP   = 2'd3
    } t_func;

    typedef struct packed {
        t_func       func;
        logic [3:0]  addr;
        logic [7:0]  wdata;
        logic        rmw;
        logic        rx_ready;
        logic [7:0]  rx_byte;
    } t_acia_in;

    typedef struct packed {
        logic [7:0]  rdata;
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        irq_line;
        logic        nmi_line;
        logic        rx_taken;
    } t_acia_out;

    typedef struct packed {
        logic [3:0] ctrl_a;
        logic [3:0] stat_a;
        logic [3:0] tx_a;
        logic [3:0] rx_a;
        logic       row_hi;
        logic       nmi;
    } t_cart_map;

    localparam logic [1:0] MODE_STD     = 2'd0;
    localparam logic [1:0] MODE_HIGH    = 2'd1;
    localparam logic [1:0] MODE_FAST    = 2'd2;
    localparam logic [1:0] MODE_STD_NMI = 2'd3;

    localparam logic [1:0] DIV_RESET = 2'd3;

    localparam logic [7:0] CTRL_RESET = 8'h03;
    localparam logic [7:0] STAT_RESET = 8'h02;
    localparam logic [7:0] BYTE_EMPTY = 8'hFF;

    localparam int unsigned STAT_RDRF = 0;
    localparam int unsigned STAT_TDRE = 1;
    localparam int unsigned STAT_OVRN = 5;
    localparam int unsigned STAT_IRQ  = 7;
    localparam int unsigned CTRL_RIE  = 7;

    localparam logic [1:0] PHASE_IDLE    = 2'd0;
    localparam logic [1:0] PHASE_SENDING = 2'd1;
    localparam logic [1:0] PHASE_QUEUED  = 2'd2;

    localparam int unsigned CPU_HZ = 985248;

    // Baud rates: low row then high row, indexed by {row, divide code}.
    localparam int unsigned BAUD_0 = 16 * 31250;
    localparam int unsigned BAUD_1 = 31250;
    localparam int unsigned BAUD_2 = 16 * 31250 / 64;
    localparam int unsigned BAUD_4 = 64 * 31250;
    localparam int unsigned BAUD_5 = 64 * 31250 / 16;
    localparam int unsigned BAUD_6 = 31250;

    localparam int unsigned RAW_0 = CPU_HZ / BAUD_0;
    localparam int unsigned RAW_1 = CPU_HZ / BAUD_1;
    localparam int unsigned RAW_2 = CPU_HZ / BAUD_2;
    localparam int unsigned RAW_4 = CPU_HZ / BAUD_4;
    localparam int unsigned RAW_5 = CPU_HZ / BAUD_5;
    localparam int unsigned RAW_6 = CPU_HZ / BAUD_6;

    localparam int unsigned PERIOD_MAX = 65535;

    function automatic logic [15:0] clamp_period(input int unsigned t);
        logic [15:0] r;
        if (t < 1) begin
            r = 16'd1;
        end else if (t > PERIOD_MAX) begin
            r = 16'hFFFF;
        end else begin
            r = t[15:0];
        end
        return r;
    endfunction

    // Unused divide code entries have no baud rate and run at one tick.
    localparam logic [15:0] PERIOD_TAB [8] = '{
        clamp_period(RAW_0), clamp_period(RAW_1), clamp_period(RAW_2), 16'd1,
        clamp_period(RAW_4), clamp_period(RAW_5), clamp_period(RAW_6), 16'd1
    };

    function automatic t_cart_map cart_map(input logic [1:0] mode);
        t_cart_map m;
        unique case (mode)
            MODE_STD:     m = '{4'd0, 4'd2, 4'd1, 4'd3, 1'b0, 1'b0};
            MODE_HIGH:    m = '{4'd8, 4'd8, 4'd9, 4'd9, 1'b0, 1'b0};
            MODE_FAST:    m = '{4'd4, 4'd6, 4'd5, 4'd7, 1'b1, 1'b0};
            MODE_STD_NMI: m = '{4'd0, 4'd2, 4'd1, 4'd3, 1'b0, 1'b1};
            default:      m = '{4'd0, 4'd2, 4'd1, 4'd3, 1'b0, 1'b0};
        endcase
        return m;
    endfunction

endpackage

// ----- hdl/midi_acia_in_reg.sv -----
// Input register: holds one bus transaction until the engine takes it.
`timescale 1ns / 1ps

module midi_acia_in_reg import midi_acia_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_acia_in i_in_data,
    input  logic     i_take,
    output logic     o_valid,
    output t_acia_in o_data
);

    logic     r_valid;
    logic     n_valid;
    t_acia_in r_data;
    logic     accept;

    // The held transaction blocks a new one only when the engine cannot take it.
    assign o_in_stall = r_valid && !i_take;
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_data <= i_in_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ----- hdl/midi_acia_engine.sv -----
// ACIA engine: register state, one-pass step logic and the result register.
`timescale 1ns / 1ps

module midi_acia_engine import midi_acia_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_wdata,
    input  logic       i_valid,
    input  t_acia_in   i_data,
    output logic       o_take,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_acia_out  o_out_data
);

    typedef struct packed {
        logic [7:0]  control;
        logic [7:0]  status;
        logic [7:0]  rx_data;
        logic [7:0]  tx_data;
        logic [1:0]  tx_phase;
        logic        irq_pend;
        logic        ports_open;
        logic        timer_armed;
        logic [15:0] countdown;
        logic [7:0]  prev_read;
    } t_acia_state;

    localparam t_acia_state STATE_RESET = '{
        control:     CTRL_RESET,
        status:      STAT_RESET,
        rx_data:     8'h00,
        tx_data:     8'h00,
        tx_phase:    PHASE_IDLE,
        irq_pend:    1'b0,
        ports_open:  1'b0,
        timer_armed: 1'b0,
        countdown:   16'd0,
        prev_read:   8'h00
    };

    function automatic t_acia_state bus_write(input t_acia_state s, input t_cart_map m,
                                              input logic [3:0] a, input logic [7:0] v);
        t_acia_state r;
        r = s;
        if (a == m.ctrl_a) begin
            r.control = v;
            if (v[1:0] != DIV_RESET) begin
                r.ports_open = 1'b1;
                if (s.tx_phase == PHASE_IDLE) begin
                    r.timer_armed = 1'b1;
                    r.countdown   = 16'd1;
                end
            end else begin
                // Master reset keeps the data bytes and the last read value.
                r.control     = CTRL_RESET;
                r.status      = STAT_RESET;
                r.tx_phase    = PHASE_IDLE;
                r.ports_open  = 1'b0;
                r.timer_armed = 1'b0;
                r.countdown   = 16'd0;
                r.irq_pend    = 1'b0;
            end
        end else if (a == m.tx_a) begin
            r.status[STAT_IRQ] = 1'b0;
            if (s.status[STAT_TDRE] && (s.control[1:0] != DIV_RESET)) begin
                r.status[STAT_TDRE] = 1'b0;
                r.tx_data = v;
                if (s.tx_phase == PHASE_IDLE) begin
                    r.timer_armed = 1'b1;
                    r.countdown   = 16'd1;
                    r.tx_phase    = PHASE_QUEUED;
                end else if (s.tx_phase == PHASE_SENDING) begin
                    r.tx_phase = PHASE_QUEUED;
                end
            end
        end
        return r;
    endfunction

    function automatic t_acia_state bus_read(input t_acia_state s, input t_cart_map m,
                                             input logic [3:0] a);
        t_acia_state r;
        r = s;
        r.prev_read = BYTE_EMPTY;
        if (a == m.stat_a) begin
            r.prev_read = s.status;
        end else if (a == m.rx_a) begin
            r.status[STAT_OVRN] = 1'b0;
            if (s.irq_pend) begin
                r.status[STAT_IRQ] = 1'b0;
                r.irq_pend = 1'b0;
            end
            if (s.status[STAT_RDRF]) begin
                r.status[STAT_RDRF] = 1'b0;
                r.prev_read = s.rx_data;
            end
        end
        return r;
    endfunction

    logic [1:0]  r_mode;
    t_acia_state r_st;
    t_acia_state n_st;
    t_acia_state st;
    logic        r_out_valid;
    logic        n_out_valid;
    t_acia_out   r_out;
    t_acia_out   res;
    t_cart_map   m;
    logic        advance;

    assign m       = cart_map(r_mode);
    assign advance = !r_out_valid || !i_out_stall;
    assign o_take  = i_valid && advance;

    always_comb begin
        st           = r_st;
        res          = '0;
        res.rdata    = BYTE_EMPTY;
        unique case (i_data.func)
            FUNC_READ: begin
                st        = bus_read(r_st, m, i_data.addr);
                res.rdata = st.prev_read;
            end
            FUNC_WRITE: begin
                if (i_data.rmw) begin
                    st = bus_write(st, m, i_data.addr, r_st.prev_read);
                end
                st = bus_write(st, m, i_data.addr, i_data.wdata);
            end
            FUNC_TICK: begin
                if (r_st.timer_armed) begin
                    if (r_st.countdown > 16'd1) begin
                        st.countdown = r_st.countdown - 16'd1;
                    end else begin
                        if ((r_st.tx_phase == PHASE_QUEUED) && r_st.ports_open) begin
                            res.tx_valid = 1'b1;
                            res.tx_byte  = r_st.tx_data;
                        end
                        if (r_st.tx_phase != PHASE_IDLE) begin
                            st.tx_phase = r_st.tx_phase - 2'd1;
                        end
                        if (r_st.ports_open && !r_st.status[STAT_RDRF] && i_data.rx_ready) begin
                            st.rx_data          = i_data.rx_byte;
                            st.status[STAT_RDRF] = 1'b1;
                            res.rx_taken        = 1'b1;
                            if (r_st.control[CTRL_RIE]) begin
                                st.status[STAT_IRQ] = 1'b1;
                                st.irq_pend         = 1'b1;
                            end
                        end
                        st.status[STAT_TDRE] = 1'b1;
                        st.countdown = PERIOD_TAB[{m.row_hi, r_st.control[1:0]}];
                    end
                end
            end
            FUNC_NOP: begin
                st = r_st;
            end
            default: begin
                st = r_st;
            end
        endcase
        res.irq_line = st.irq_pend && !m.nmi;
        res.nmi_line = st.irq_pend && m.nmi;

        n_st        = o_take ? st : r_st;
        n_out_valid = o_take || (r_out_valid && i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_STD;
            r_st        <= STATE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            r_st        <= n_st;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ----- hdl/midi_acia_cartridge_top.sv -----
// Top level of the MIDI ACIA cartridge: input register feeding the ACIA engine.
`timescale 1ns / 1ps
// A transaction passes the input register, then the result register. The block takes one transaction
// per cycle unless the result stalls; the state update is one feedback loop. A stalled result holds
// the engine; the input register then takes one more transaction. Reset (synchronous, active low)
// empties both registers and loads the ACIA reset state. Configuration writes take effect at the
// next edge; the user must make them only while the block is idle, which the block does not enforce.

module midi_acia_cartridge_top import midi_acia_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Configuration: interface mode (address map, baud row, interrupt kind).
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_wdata,
    // Bus, tick and host receive transactions.
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_acia_in   i_in_data,
    // Read data, transmitted byte and interrupt lines, one result per transaction.
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_acia_out  o_out_data
);

    logic     in_valid;
    t_acia_in in_data;
    logic     take;

    // The input register holds one transaction ahead of the result register;
    // it stalls only while holding a transaction that the engine cannot take.
    midi_acia_in_reg u_in_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_take     (take),
        .o_valid    (in_valid),
        .o_data     (in_data)
    );

    // The engine holds all ACIA state and computes each transaction's effect in
    // one pass, writing the new state and the result register together.
    midi_acia_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (in_valid),
        .i_data      (in_data),
        .o_take      (take),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

// ----- hdl/midi_acia_checker.sv -----
// Port-level checker for the MIDI ACIA cartridge, bound to the top level.
`timescale 1ns / 1ps
`include "midi_acia_cartridge_top_defines.svh"

module midi_acia_cartridge_sva import midi_acia_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_cfg_we,
    input logic [1:0] i_cfg_wdata,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input t_acia_in   i_in_data,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input t_acia_out  o_out_data
);

    `MA_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data), "stalled result changed")
    `MA_ASSERT_RESET(a_reset_empty, !i_rst_n, !o_out_valid, "result valid after reset")
    `MA_ASSERT_NOW(a_stall_cause, o_in_stall, o_out_valid && i_out_stall, "input stalled without a blocked result")
    `MA_ASSERT_NOW(a_one_line, o_out_valid, !(o_out_data.irq_line && o_out_data.nmi_line), "IRQ and NMI both asserted")
    `MA_ASSERT_NOW(a_tx_idle_zero, o_out_valid && !o_out_data.tx_valid, o_out_data.tx_byte == 8'h00, "transmit byte set without transmit")

endmodule

bind midi_acia_cartridge_top midi_acia_cartridge_sva u_checker (.*);

// ----- tb/midi_acia_checker.sv -----
// Checker for the MIDI ACIA cartridge: predicts every result and compares it with the block.
`timescale 1ns / 1ps

module midi_acia_checker import midi_acia_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_wdata,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  t_acia_in   i_in_data,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  t_acia_out  i_out_data,
    output int         o_fail_count,
    output int         o_outstanding
);

    // Predicted ACIA state.
    logic [1:0]  mode;
    logic [7:0]  ctrl_q;
    logic [7:0]  stat_q;
    logic [7:0]  rx_hold;
    logic [7:0]  tx_hold;
    logic [7:0]  last_read;
    logic [1:0]  tx_phase;
    logic        irq_pend;
    logic        open_q;
    logic        armed_q;
    logic [15:0] countdown;

    t_acia_out   pending_results [$];
    t_acia_out   want;
    int          mismatches = 0;

    assign o_fail_count = mismatches;

    function automatic t_cart_map decode_map(input logic [1:0] m);
        t_cart_map r;
        case (m)
            MODE_HIGH:    r = '{4'd8, 4'd8, 4'd9, 4'd9, 1'b0, 1'b0};
            MODE_FAST:    r = '{4'd4, 4'd6, 4'd5, 4'd7, 1'b1, 1'b0};
            MODE_STD_NMI: r = '{4'd0, 4'd2, 4'd1, 4'd3, 1'b0, 1'b1};
            default:      r = '{4'd0, 4'd2, 4'd1, 4'd3, 1'b0, 1'b0};
        endcase
        return r;
    endfunction

    // Character period in CPU ticks for the current mode and divide code.
    function automatic logic [15:0] char_ticks();
        t_cart_map   m;
        int unsigned rate;
        int unsigned t;
        m = decode_map(mode);
        case ({m.row_hi, ctrl_q[1:0]})
            3'b000:  rate = 16 * 31250;
            3'b001:  rate = 31250;
            3'b010:  rate = 16 * 31250 / 64;
            3'b100:  rate = 64 * 31250;
            3'b101:  rate = 64 * 31250 / 16;
            3'b110:  rate = 31250;
            default: rate = 0;
        endcase
        t = (rate != 0) ? CPU_HZ / rate : 1;
        if (t < 1) t = 1;
        if (t > 65535) t = 65535;
        return t[15:0];
    endfunction

    function automatic void clear_engine();
        ctrl_q    = CTRL_RESET;
        stat_q    = STAT_RESET;
        tx_phase  = PHASE_IDLE;
        open_q    = 1'b0;
        armed_q   = 1'b0;
        countdown = '0;
        irq_pend  = 1'b0;
    endfunction

    function automatic void bus_write(input logic [3:0] a, input logic [7:0] v);
        t_cart_map m;
        m = decode_map(mode);
        if (a == m.ctrl_a) begin
            ctrl_q = v;
            if (v[1:0] != DIV_RESET) begin
                open_q = 1'b1;
                if (tx_phase == PHASE_IDLE) begin
                    armed_q   = 1'b1;
                    countdown = 16'd1;
                end
            end else begin
                clear_engine();
            end
        end else if (a == m.tx_a) begin
            stat_q[STAT_IRQ] = 1'b0;
            if (stat_q[STAT_TDRE] && ctrl_q[1:0] != DIV_RESET) begin
                stat_q[STAT_TDRE] = 1'b0;
                tx_hold = v;
                if (tx_phase == PHASE_IDLE) begin
                    armed_q   = 1'b1;
                    countdown = 16'd1;
                    tx_phase  = PHASE_QUEUED;
                end else if (tx_phase == PHASE_SENDING) begin
                    tx_phase = PHASE_QUEUED;
                end
            end
        end
    endfunction

    function automatic logic [7:0] bus_read(input logic [3:0] a);
        t_cart_map m;
        m = decode_map(mode);
        last_read = BYTE_EMPTY;
        if (a == m.stat_a) begin
            last_read = stat_q;
        end else if (a == m.rx_a) begin
            stat_q[STAT_OVRN] = 1'b0;
            if (irq_pend) begin
                stat_q[STAT_IRQ] = 1'b0;
                irq_pend = 1'b0;
            end
            if (stat_q[STAT_RDRF]) begin
                stat_q[STAT_RDRF] = 1'b0;
                last_read = rx_hold;
            end
        end
        return last_read;
    endfunction

    function automatic t_acia_out predict_response(input t_acia_in it);
        t_acia_out r;
        t_cart_map m;
        r = '0;
        r.rdata = BYTE_EMPTY;
        case (it.func)
            FUNC_READ: begin
                r.rdata = bus_read(it.addr);
            end
            FUNC_WRITE: begin
                if (it.rmw) bus_write(it.addr, last_read);
                bus_write(it.addr, it.wdata);
            end
            FUNC_TICK: begin
                if (armed_q) begin
                    if (countdown > 16'd1) begin
                        countdown = countdown - 16'd1;
                    end else begin
                        if (tx_phase == PHASE_QUEUED && open_q) begin
                            r.tx_valid = 1'b1;
                            r.tx_byte  = tx_hold;
                        end
                        if (tx_phase != PHASE_IDLE) tx_phase = tx_phase - 2'd1;
                        if (open_q && !stat_q[STAT_RDRF] && it.rx_ready) begin
                            rx_hold = it.rx_byte;
                            stat_q[STAT_RDRF] = 1'b1;
                            r.rx_taken = 1'b1;
                            if (ctrl_q[CTRL_RIE]) begin
                                stat_q[STAT_IRQ] = 1'b1;
                                irq_pend = 1'b1;
                            end
                        end
                        stat_q[STAT_TDRE] = 1'b1;
                        countdown = char_ticks();
                    end
                end
            end
            default: begin
            end
        endcase
        m = decode_map(mode);
        r.irq_line = irq_pend && !m.nmi;
        r.nmi_line = irq_pend && m.nmi;
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("[%0t] acia mismatch: %s", $time, what);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mode      = MODE_STD;
            rx_hold   = '0;
            tx_hold   = '0;
            last_read = '0;
            clear_engine();
            pending_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("result arrived with no transaction outstanding");
                end else begin
                    want = pending_results.pop_front();
                    if (i_out_data.rdata !== want.rdata)
                        report_mismatch($sformatf("rdata expected %02h got %02h",
                                                  want.rdata, i_out_data.rdata));
                    if (i_out_data.tx_valid !== want.tx_valid)
                        report_mismatch($sformatf("tx_valid expected %0b got %0b",
                                                  want.tx_valid, i_out_data.tx_valid));
                    if (i_out_data.tx_byte !== want.tx_byte)
                        report_mismatch($sformatf("tx_byte expected %02h got %02h",
                                                  want.tx_byte, i_out_data.tx_byte));
                    if (i_out_data.irq_line !== want.irq_line)
                        report_mismatch($sformatf("irq_line expected %0b got %0b",
                                                  want.irq_line, i_out_data.irq_line));
                    if (i_out_data.nmi_line !== want.nmi_line)
                        report_mismatch($sformatf("nmi_line expected %0b got %0b",
                                                  want.nmi_line, i_out_data.nmi_line));
                    if (i_out_data.rx_taken !== want.rx_taken)
                        report_mismatch($sformatf("rx_taken expected %0b got %0b",
                                                  want.rx_taken, i_out_data.rx_taken));
                end
            end
            if (i_in_valid && !i_in_stall) pending_results.push_back(predict_response(i_in_data));
            if (i_cfg_we) mode = i_cfg_wdata;
        end
        o_outstanding <= pending_results.size();
    end

endmodule

// ----- tb/tb.sv -----
// Testbench top for the MIDI ACIA cartridge: clock, reset, stimulus, stall pattern and verdict.
`timescale 1ns / 1ps

module tb;
    import midi_acia_pkg::*;

    // Half of the 12 ns clock period.
    localparam int CLK_HALF = 6;

    // Counter divide codes of the control register, beside the reset code in the package.
    localparam logic [1:0] DIV_BY_1  = 2'd0;
    localparam logic [1:0] DIV_BY_16 = 2'd1;
    localparam logic [1:0] DIV_BY_64 = 2'd2;

    localparam int PHASE_COUNT      = 6;
    localparam int ITEMS_PER_PHASE  = 180;
    localparam int LONG_HOLD_CYCLES = 64;

    // Modes visited by the random phases, both extremes among them.
    localparam logic [1:0] PHASE_MODES [PHASE_COUNT] = '{
        MODE_STD_NMI, MODE_FAST, MODE_HIGH, MODE_STD, MODE_FAST, MODE_STD_NMI
    };

    logic       clk;
    logic       rst_n     = 1'b0;
    logic       cfg_we    = 1'b0;
    logic [1:0] cfg_wdata = 2'd0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    t_acia_in   in_data   = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    t_acia_out  out_data;

    int fail_count;
    int outstanding;

    // Idling controls, changed by the stimulus between phases.
    bit sender_idles   = 1'b0;
    bit receiver_idles = 1'b0;
    int holds_asked    = 0;
    int holds_served   = 0;

    midi_acia_cartridge_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    midi_acia_checker acia_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_wdata   (cfg_wdata),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_in_data     (in_data),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_out_data    (out_data),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    initial begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // A hard ceiling on the run; a correct run needs only a small fraction of it.
    initial begin
        #(2 * CLK_HALF * 400000);
        $display("TEST FAILED");
        $finish;
    end

    function automatic t_acia_in mk(input t_func f, input logic [3:0] a, input logic [7:0] d,
                                    input logic rmw, input logic rdy, input logic [7:0] rb);
        t_acia_in it;
        it.func     = f;
        it.addr     = a;
        it.wdata    = d;
        it.rmw      = rmw;
        it.rx_ready = rdy;
        it.rx_byte  = rb;
        return it;
    endfunction

    // Most transactions are well-formed register traffic and ticks for the current map;
    // the rest hit random addresses, so unmapped reads and writes are exercised too.
    // Every field but the operation is randomised first, so that all bits toggle whatever the operation.
    function automatic t_acia_in random_item(input t_cart_map m);
        t_acia_in    it;
        int unsigned pick;
        int unsigned sub;
        it.addr     = 4'($urandom_range(0, 15));
        it.wdata    = 8'($urandom_range(0, 255));
        it.rmw      = 1'($urandom_range(0, 1));
        it.rx_ready = 1'($urandom_range(0, 1));
        it.rx_byte  = 8'($urandom_range(0, 255));
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            it.func = FUNC_TICK;
        end else if (pick < 68) begin
            it.func = FUNC_READ;
            sub = $urandom_range(0, 9);
            if (sub < 5) begin
                it.addr = m.stat_a;
            end else if (sub < 8) begin
                it.addr = m.rx_a;
            end
        end else if (pick < 96) begin
            it.func = FUNC_WRITE;
            it.rmw  = ($urandom_range(0, 4) == 0);
            sub = $urandom_range(0, 9);
            if (sub < 7) begin
                it.addr = m.tx_a;
            end else if (sub < 9) begin
                // Mostly the fastest divide, so that characters move often; the slow
                // ones and the reset code turn up now and again.
                it.addr = m.ctrl_a;
                sub = $urandom_range(0, 19);
                if (sub < 11) begin
                    it.wdata[1:0] = DIV_BY_1;
                end else if (sub < 16) begin
                    it.wdata[1:0] = DIV_BY_16;
                end else if (sub < 17) begin
                    it.wdata[1:0] = DIV_BY_64;
                end else begin
                    it.wdata[1:0] = DIV_RESET;
                end
            end
        end else begin
            it.func = FUNC_NOP;
        end
        return it;
    endfunction

    // Offers one transaction and returns at the edge where it is taken. Valid stays high
    // for the next transaction unless a random gap is inserted first.
    task automatic send(input t_acia_in it);
        int gap;
        if (sender_idles && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 7);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (in_stall);
    endtask

    // Stops offering and waits until every predicted result has been received.
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    // The mode register is only written once the block has gone quiet.
    task automatic set_mode(input logic [1:0] m);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Receiver side: random stall bursts when enabled, and on request one long hold-off
    // counted here in cycles, during which the sender keeps offering so that the block
    // fills up and has to stall its input.
    initial begin
        int burst;
        forever begin
            @(posedge clk);
            if (holds_asked != holds_served) begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
                holds_served++;
            end else if (receiver_idles && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(1, 7);
                out_stall <= 1'b1;
                repeat (burst) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    initial begin
        t_cart_map m;
        int        n;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, in the standard map that reset selects. Sender and receiver
        // stay busy here, so the expected sequence is easy to follow in a waveform.
        m = cart_map(MODE_STD);
        send(mk(FUNC_READ,  m.stat_a, 8'h00, 1'b0, 1'b0, 8'h00)); // transmit empty only
        send(mk(FUNC_READ,  m.rx_a,   8'h00, 1'b0, 1'b0, 8'h00)); // nothing received yet
        send(mk(FUNC_TICK,  4'h0,     8'h00, 1'b0, 1'b1, 8'h12)); // timer not yet armed
        // A transmit write while the divide code still holds reset is dropped.
        send(mk(FUNC_WRITE, m.tx_a,   8'hA5, 1'b0, 1'b0, 8'h00));
        // Open the ports at the fastest rate with receive interrupts enabled.
        send(mk(FUNC_WRITE, m.ctrl_a, 8'h80, 1'b0, 1'b0, 8'h00));
        send(mk(FUNC_WRITE, m.tx_a,   8'hFF, 1'b0, 1'b0, 8'h00));
        // Second byte while the transmit register is full is dropped.
        send(mk(FUNC_WRITE, m.tx_a,   8'h5A, 1'b0, 1'b0, 8'h00));
        // Character event: byte out, host byte in, interrupt raised, transmit empty again.
        send(mk(FUNC_TICK,  4'h0,     8'h00, 1'b0, 1'b1, 8'hFF));
        send(mk(FUNC_READ,  m.stat_a, 8'h00, 1'b0, 1'b0, 8'h00));
        // Receive register still full, so the host byte is refused.
        send(mk(FUNC_TICK,  4'h0,     8'h00, 1'b0, 1'b1, 8'h00));
        send(mk(FUNC_READ,  m.rx_a,   8'h00, 1'b0, 1'b0, 8'h00)); // clears the interrupt
        send(mk(FUNC_READ,  m.rx_a,   8'h00, 1'b0, 1'b0, 8'h00)); // empty again
        // Read-modify-write: the last read byte is replayed, the new byte is then dropped.
        send(mk(FUNC_WRITE, m.tx_a,   8'h00, 1'b1, 1'b0, 8'h00));
        send(mk(FUNC_TICK,  4'h0,     8'h00, 1'b0, 1'b1, 8'h00));
        // Replaying 0xFF to the control register resets the block before the new value.
        send(mk(FUNC_WRITE, m.ctrl_a, 8'h00, 1'b1, 1'b0, 8'h00));
        send(mk(FUNC_READ,  4'hF,     8'h00, 1'b0, 1'b0, 8'h00)); // unmapped address
        send(mk(FUNC_NOP,   4'hF,     8'hFF, 1'b1, 1'b1, 8'hFF)); // no operation
        // Slowest divide, then a tick to reload the long character period.
        send(mk(FUNC_WRITE, m.ctrl_a, 8'hFE, 1'b0, 1'b0, 8'h00));
        send(mk(FUNC_TICK,  4'h0,     8'h00, 1'b0, 1'b0, 8'h00));
        // Divide code three: reset, after which ticks do nothing.
        send(mk(FUNC_WRITE, m.ctrl_a, 8'h03, 1'b0, 1'b0, 8'h00));
        send(mk(FUNC_TICK,  4'h0,     8'h00, 1'b0, 1'b1, 8'h77));
        send(mk(FUNC_WRITE, m.ctrl_a, 8'h81, 1'b0, 1'b0, 8'h00));
        send(mk(FUNC_READ,  m.stat_a, 8'h00, 1'b0, 1'b0, 8'h00));

        // Random phases, one per mode setting. Idling is switched off in some middle
        // phases and in the final part of the run.
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            set_mode(PHASE_MODES[phase]);
            m = cart_map(PHASE_MODES[phase]);
            sender_idles   = (phase < 4) && (phase != 2);
            receiver_idles = (phase < 4) && (phase != 3);
            if (phase == 1) holds_asked++;
            // Open the ports at the fastest rate so that the phase gets going at once.
            n = $urandom_range(0, 63);
            send(mk(FUNC_WRITE, m.ctrl_a, {n[5:0], DIV_BY_1}, 1'b0, 1'b0, 8'h00));
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                send(random_item(m));
            end
        end

        // Wait for the last results, then keep the clock running in case of a stray one.
        drain();
        repeat (8) @(posedge clk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/midi_acia_pkg.sv
hdl/midi_acia_in_reg.sv
hdl/midi_acia_engine.sv
hdl/midi_acia_cartridge_top.sv
hdl/midi_acia_checker.sv
tb/midi_acia_checker.sv
tb/tb.sv
